/* hdl/atmc_pkg.sv */
// Package for the activity / temperature / mount classifier.
// Types, field widths, register codes and reset values shared by every file.
// No dependencies.
package atmc_pkg;

    localparam int TEMP_W     = 12;
    localparam int PRESS_W    = 12;
    localparam int MAG_W      = 16;
    localparam int CNT_W      = 8;
    localparam int LVL_W      = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [MAG_W-1:0]          RST_HIGH_LEVEL  = 16'd4096;
    localparam logic [MAG_W-1:0]          RST_MED_LEVEL   = 16'd3072;
    localparam logic signed [TEMP_W-1:0]  RST_TEMP_LEVEL  = 12'sd632;
    localparam logic [PRESS_W-1:0]        RST_PRESS_LEVEL = 12'd2048;
    localparam logic [CNT_W-1:0]          RST_ALERT_COUNT = 8'd5;

    typedef enum logic [LVL_W-1:0] {
        LVL_NONE      = 2'd0,
        LVL_POSSIBLE  = 2'd1,
        LVL_PROBABLE  = 2'd2,
        LVL_CONFIRMED = 2'd3
    } t_level;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_HIGH_LEVEL  = 3'd0,
        REG_MED_LEVEL   = 3'd1,
        REG_TEMP_LEVEL  = 3'd2,
        REG_PRESS_LEVEL = 3'd3,
        REG_ALERT_COUNT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [MAG_W-1:0]         high_level;
        logic [MAG_W-1:0]         med_level;
        logic signed [TEMP_W-1:0] temp_level;
        logic [PRESS_W-1:0]       press_level;
        logic [CNT_W-1:0]         alert_count;
    } t_cfg;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SQUARE = 2'd1,
        ST_ROOT   = 2'd2,
        ST_FINISH = 2'd3
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic  load;     // capture sample, clear accumulators
        logic  sq_mul;   // square the selected axis
        t_axis sq_sel;
        logic  sq_acc;   // add last square into the sum
        logic  rt_step;  // one root iteration
        logic  fin;      // grade, update counter, load result
    } t_cmd;

    // datapath / output side -> controller
    typedef struct packed {
        logic out_full;
        logic out_take;
    } t_sts;

endpackage

/* hdl/atmc_sample_if.sv */
// Sample and result channel interfaces for the classifier.
// Depends on atmc_pkg for field widths.
interface atmc_sample_if import atmc_pkg::*; #(
    parameter int ACCEL_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ACCEL_WIDTH-1:0] accel_x;
    logic signed [ACCEL_WIDTH-1:0] accel_y;
    logic signed [ACCEL_WIDTH-1:0] accel_z;
    logic signed [TEMP_W-1:0]      temperature;
    logic [PRESS_W-1:0]            pressure_reading;

    modport source (output valid, accel_x, accel_y, accel_z, temperature, pressure_reading,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, temperature, pressure_reading,
                    output ready);
endinterface

interface atmc_result_if import atmc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LVL_W-1:0]   level;
    logic               high_activity;
    logic               temperature_high;
    logic               mount_seen;
    logic [MAG_W-1:0]   magnitude;
    logic [CNT_W-1:0]   activity_count;

    modport source (output valid, level, high_activity, temperature_high, mount_seen,
                    magnitude, activity_count, input ready);
    modport sink   (input valid, level, high_activity, temperature_high, mount_seen,
                    magnitude, activity_count, output ready);
endinterface

/* hdl/atmc_regs.sv */
// APB register file for the classifier thresholds.
// Depends on atmc_pkg.
module atmc_regs import atmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[APB_ADDR_W-1:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_HIGH_LEVEL:  n_cfg.high_level  = i_pwdata[MAG_W-1:0];
                REG_MED_LEVEL:   n_cfg.med_level   = i_pwdata[MAG_W-1:0];
                REG_TEMP_LEVEL:  n_cfg.temp_level  = $signed(i_pwdata[TEMP_W-1:0]);
                REG_PRESS_LEVEL: n_cfg.press_level = i_pwdata[PRESS_W-1:0];
                REG_ALERT_COUNT: n_cfg.alert_count = i_pwdata[CNT_W-1:0];
                default: ;  // unmapped, dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HIGH_LEVEL:  o_prdata = APB_DATA_W'(r_cfg.high_level);
            REG_MED_LEVEL:   o_prdata = APB_DATA_W'(r_cfg.med_level);
            REG_TEMP_LEVEL:  o_prdata = APB_DATA_W'($signed(r_cfg.temp_level));
            REG_PRESS_LEVEL: o_prdata = APB_DATA_W'(r_cfg.press_level);
            REG_ALERT_COUNT: o_prdata = APB_DATA_W'(r_cfg.alert_count);
            default:         o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_level  <= RST_HIGH_LEVEL;
            r_cfg.med_level   <= RST_MED_LEVEL;
            r_cfg.temp_level  <= RST_TEMP_LEVEL;
            r_cfg.press_level <= RST_PRESS_LEVEL;
            r_cfg.alert_count <= RST_ALERT_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* hdl/atmc_ctrl.sv */
// Sequencing state machine: squaring, root iterations, result hand-off.
// Depends on atmc_pkg.
module atmc_ctrl import atmc_pkg::*; #(
    parameter int ACCEL_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam int STEP_W = $clog2((ACCEL_WIDTH > 4) ? ACCEL_WIDTH : 4);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ACCEL_WIDTH - 1);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              w_out_free;

    assign w_out_free = !i_sts.out_full || i_sts.out_take;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_step == SQ_LAST) begin
                    n_state = ST_ROOT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_ROOT: begin
                if (r_step == ROOT_LAST) begin
                    n_state = ST_FINISH;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.sq_sel   = AXIS_X;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SQUARE: begin
                o_cmd.sq_mul = (r_step != SQ_LAST);
                o_cmd.sq_sel = t_axis'(r_step[1:0]);
                o_cmd.sq_acc = (r_step != '0);
            end
            ST_ROOT: begin
                o_cmd.rt_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.fin = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* hdl/atmc_dp.sv */
// Datapath: shared squarer, accumulator, bit-per-cycle square root,
// threshold compares, activity counter and result register. Depends on atmc_pkg.
module atmc_dp import atmc_pkg::*; #(
    parameter int ACCEL_WIDTH = 16,
    parameter int COUNTER_MAX = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_cfg                          i_cfg,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_x,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_y,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_z,
    input  logic signed [TEMP_W-1:0]      i_temperature,
    input  logic [PRESS_W-1:0]            i_pressure,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [LVL_W-1:0]              o_level,
    output logic                          o_high_activity,
    output logic                          o_temperature_high,
    output logic                          o_mount_seen,
    output logic [MAG_W-1:0]              o_magnitude,
    output logic [CNT_W-1:0]              o_activity_count
);

    localparam int AW    = ACCEL_WIDTH;
    localparam int SUM_W = 2 * AW;            // 3 * 2^(2AW-2) still fits
    localparam int REM_W = AW + 2;
    localparam int RW    = (AW > MAG_W) ? AW : MAG_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNTER_MAX);

    // captured sample
    logic signed [AW-1:0]      r_ax, r_ay, r_az;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [PRESS_W-1:0]        r_press;
    // arithmetic
    logic [SUM_W-1:0]          r_prod;
    logic [SUM_W-1:0]          r_sum;
    logic [REM_W-1:0]          r_rem;
    logic [AW-1:0]             r_root;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    // result word
    logic                      r_ovalid;
    t_level                    r_level;
    t_level                    n_level;
    logic                      r_hi, r_temp_hi, r_mount;
    logic [MAG_W-1:0]          r_mag;

    logic signed [AW-1:0]      w_op;
    logic [AW-1:0]             w_abs;
    logic [SUM_W-1:0]          w_sq;
    logic [REM_W+1:0]          w_rem_sh;
    logic [REM_W+1:0]          w_trial;
    logic [REM_W+1:0]          w_diff;
    logic                      w_ge;
    logic [RW-1:0]             w_root_ext;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_hi, w_med, w_temp_hi, w_mount, w_alert;
    logic [CNT_W-1:0]          w_cnt_c;

    // squarer, one axis per cycle
    always_comb begin
        unique case (i_cmd.sq_sel)
            AXIS_X:  w_op = r_ax;
            AXIS_Y:  w_op = r_ay;
            default: w_op = r_az;
        endcase
    end
    assign w_abs = w_op[AW-1] ? AW'(-w_op) : AW'(w_op);
    assign w_sq  = w_abs * w_abs;

    // restoring root: two radicand bits in, one root bit out
    assign w_rem_sh = {r_rem, r_sum[SUM_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    // grading
    assign w_root_ext = RW'(r_root);
    assign w_mag      = (w_root_ext > RW'(MAG_MAX)) ? MAG_MAX : w_root_ext[MAG_W-1:0];
    assign w_hi       = (w_mag >= i_cfg.high_level);
    assign w_med      = (w_mag >= i_cfg.med_level);
    assign w_temp_hi  = ($signed(r_temp) >= $signed(i_cfg.temp_level));
    assign w_mount    = (r_press >= i_cfg.press_level);
    assign w_cnt_c    = (r_cnt > CNT_MAX) ? CNT_MAX : r_cnt;

    always_comb begin
        n_cnt = w_cnt_c;
        if (w_hi) begin
            if (w_cnt_c < CNT_MAX) n_cnt = w_cnt_c + CNT_W'(1);
        end else begin
            if (w_cnt_c != '0) n_cnt = w_cnt_c - CNT_W'(1);
        end
    end

    assign w_alert = (n_cnt >= i_cfg.alert_count);

    always_comb begin
        priority if (w_mount && (w_med || w_temp_hi)) begin
            n_level = LVL_CONFIRMED;
        end else if (w_alert && w_temp_hi) begin
            n_level = LVL_PROBABLE;
        end else if (w_alert || w_temp_hi || w_mount) begin
            n_level = LVL_POSSIBLE;
        end else begin
            n_level = LVL_NONE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_ovalid <= 1'b1;
                r_cnt    <= n_cnt;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_temp  <= i_temperature;
            r_press <= i_pressure;
            r_sum   <= '0;
            r_rem   <= '0;
            r_root  <= '0;
        end else begin
            if (i_cmd.sq_acc) begin
                r_sum <= r_sum + r_prod;
            end
            if (i_cmd.rt_step) begin
                r_sum  <= r_sum << 2;
                r_root <= {r_root[AW-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            end
        end
        if (i_cmd.sq_mul) begin
            r_prod <= w_sq;
        end
        if (i_cmd.fin) begin
            r_level   <= n_level;
            r_hi      <= w_hi;
            r_temp_hi <= w_temp_hi;
            r_mount   <= w_mount;
            r_mag     <= w_mag;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_level            = r_level;
    assign o_high_activity    = r_hi;
    assign o_temperature_high = r_temp_hi;
    assign o_mount_seen       = r_mount;
    assign o_magnitude        = r_mag;
    assign o_activity_count   = r_cnt;

endmodule

/* hdl/activity_temp_mount_classifier.sv */
// Top level of the activity / temperature / mount classifier.
// Depends on atmc_pkg, atmc_sample_if, atmc_result_if, atmc_regs, atmc_ctrl, atmc_dp.

// Takes one sensor sample word at a time and returns one result word per sample.
// A sample is taken in the idle state, squared axis by axis through one shared
// ACCEL_WIDTH x ACCEL_WIDTH multiplier, run through the bit-per-cycle square
// root and graded in the finish state; only then does the block return to idle,
// so it takes no new sample until the last one has been graded. The result sits
// in an output register; the next sample is accepted while it waits, and the
// block only holds in its finish state if the previous result has still not
// been taken. The sample interface must be built with the same ACCEL_WIDTH.
// Thresholds sit on the APB port, byte address 4*n (paddr[1:0] is ignored):
// 0 high activity level, 1 medium activity level, 2 temperature level (signed,
// sign-extended on read), 3 pressure level, 4 alert count; other word indices
// read zero and ignore writes. Write them only while idle. The high-activity
// counter saturates at COUNTER_MAX and is clamped to it before each update.
module activity_temp_mount_classifier import atmc_pkg::*; #(
    parameter int ACCEL_WIDTH = 16,
    parameter int COUNTER_MAX = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    atmc_sample_if.sink           i_sample,
    atmc_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_out_valid;

    atmc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // result register status back to the sequencer
    assign w_sts.out_full = w_out_valid;
    assign w_sts.out_take = w_out_valid & o_result.ready;

    atmc_ctrl #(
        .ACCEL_WIDTH (ACCEL_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_sample.ready),
        .o_cmd      (w_cmd)
    );

    atmc_dp #(
        .ACCEL_WIDTH (ACCEL_WIDTH),
        .COUNTER_MAX (COUNTER_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_cfg              (w_cfg),
        .i_accel_x          (i_sample.accel_x),
        .i_accel_y          (i_sample.accel_y),
        .i_accel_z          (i_sample.accel_z),
        .i_temperature      (i_sample.temperature),
        .i_pressure         (i_sample.pressure_reading),
        .i_out_ready        (o_result.ready),
        .o_out_valid        (w_out_valid),
        .o_level            (o_result.level),
        .o_high_activity    (o_result.high_activity),
        .o_temperature_high (o_result.temperature_high),
        .o_mount_seen       (o_result.mount_seen),
        .o_magnitude        (o_result.magnitude),
        .o_activity_count   (o_result.activity_count)
    );

    assign o_result.valid = w_out_valid;

endmodule

/* hdl/atmc_chk.sv */
// Port-level checks for the classifier, bound onto the top level.
// Depends on atmc_pkg and activity_temp_mount_classifier.
module atmc_chk import atmc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [LVL_W-1:0]   i_level,
    input logic               i_temp_high,
    input logic               i_mount,
    input logic [MAG_W-1:0]   i_magnitude,
    input logic [CNT_W-1:0]   i_count
);

    // stalled result keeps valid, level, magnitude and count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level)
            && $stable(i_magnitude) && $stable(i_count))
        else $error("result word changed while stalled");

    // one sample in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample accepted while still busy");

    a_confirmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_level == LVL_CONFIRMED) |-> i_mount)
        else $error("confirmed grade without mount");

    a_probable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_level == LVL_PROBABLE) |-> i_temp_high && !i_mount)
        else $error("probable grade with wrong flags");

    a_flags_grade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mount || i_temp_high) |-> (i_level != LVL_NONE))
        else $error("flag set but grade none");

endmodule

bind activity_temp_mount_classifier atmc_chk u_atmc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_level     (o_result.level),
    .i_temp_high (o_result.temperature_high),
    .i_mount     (o_result.mount_seen),
    .i_magnitude (o_result.magnitude),
    .i_count     (o_result.activity_count)
);
